[sv/wrhs_pkg.sv]
// ----------------------------------------------------------------------------
// wrhs_pkg: shared types for the water ripple height step
// transaction payloads, command codes and sequencer states
// ----------------------------------------------------------------------------
package wrhs_pkg;

   localparam int HeightW = 13;
   localparam int CoordW  = 7;
   localparam logic [HeightW-1:0] HeightLimitReset = 13'd384;

   typedef enum logic {
      CMD_POKE    = 1'b0,
      CMD_ADVANCE = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type              cmd;
      logic [CoordW-1:0]    cell_x;
      logic [CoordW-1:0]    cell_y;
      logic [HeightW-1:0]   poke_value;
   } req_type;

   typedef struct packed {
      logic [HeightW-1:0]   height;
      logic [CoordW-1:0]    out_x;
      logic [CoordW-1:0]    out_y;
      logic                 frame_last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_ACC,
      ST_CALC,
      ST_WRITE
   } state_type;

   // control from sequencer to grid memories
   typedef struct packed {
      logic       wr_en;
      logic       wr_prev;   // write previous grid, else current grid
      logic       clear;     // write both grids with zero
   } mem_ctl_type;

endpackage

[sv/wrhs_grids.sv]
// ----------------------------------------------------------------------------
// wrhs_grids: the two height grid memories
// one write port per grid, one registered read port per grid
// ----------------------------------------------------------------------------
module wrhs_grids
   import wrhs_pkg::*;
#(
   parameter int ADDR_W = 14
) (
   input  logic                clock,
   input  logic                cur_is_b,
   input  mem_ctl_type         ctl,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  logic [HeightW-1:0]  wr_data,
   input  logic [ADDR_W-1:0]   cur_addr,
   input  logic [ADDR_W-1:0]   prev_addr,
   output logic [HeightW-1:0]  cur_data,
   output logic [HeightW-1:0]  prev_data
);

   logic [HeightW-1:0] mem_a [2**ADDR_W];
   logic [HeightW-1:0] mem_b [2**ADDR_W];
   logic [HeightW-1:0] a_rd_ff, b_rd_ff;
   logic               sel_b_ff;
   logic               wr_a, wr_b;
   logic [ADDR_W-1:0]  a_addr, b_addr;

   // route write to the grid playing the requested role
   always_comb begin
      wr_a = ctl.clear | (ctl.wr_en & (cur_is_b == ctl.wr_prev));
      wr_b = ctl.clear | (ctl.wr_en & (cur_is_b != ctl.wr_prev));
      a_addr = cur_is_b ? prev_addr : cur_addr;
      b_addr = cur_is_b ? cur_addr : prev_addr;
   end

   // grid a
   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a[wr_addr] <= ctl.clear ? '0 : wr_data;
      end
      a_rd_ff <= mem_a[a_addr];
   end

   // grid b
   always_ff @(posedge clock) begin
      if (wr_b) begin
         mem_b[wr_addr] <= ctl.clear ? '0 : wr_data;
      end
      b_rd_ff <= mem_b[b_addr];
   end

   always_ff @(posedge clock) begin
      sel_b_ff <= cur_is_b;
   end

   assign cur_data  = sel_b_ff ? b_rd_ff : a_rd_ff;
   assign prev_data = sel_b_ff ? a_rd_ff : b_rd_ff;

endmodule

[sv/water_ripple_height_step.sv]
// Sequence: a poke is written back directly; an advance reads nine current-grid taps
// over one read port, then computes and writes back.
// Throughput: one transaction in flight; an advance or a poke holds the sequencer until its write-back.
// A result waiting in the result register holds the next advance in its compute step.
// Reset: a clearing pass writes zero to both grids, during which req_stall stays high;
// height_limit resets to 384.
// ----------------------------------------------------------------------------
// water_ripple_height_step: top level of the water ripple sweep
// sequencer, neighbor accumulation and result register around the grids
// ----------------------------------------------------------------------------
module water_ripple_height_step
   import wrhs_pkg::*;
#(
   parameter int GRID_W = 128,
   parameter int GRID_H = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_wr_en,
   input  logic [HeightW-1:0]  csr_wr_data
);

   localparam int XW     = $clog2(GRID_W);
   localparam int YW     = $clog2(GRID_H);
   localparam int ADDR_W = XW + YW;
   localparam int SUM_W  = HeightW + 3;
   localparam logic [XW-1:0] XLast = XW'(GRID_W - 2);
   localparam logic [YW-1:0] YLast = YW'(GRID_H - 2);

   state_type           state_ff, state_in;
   logic [HeightW-1:0]  limit_ff;
   logic                cur_is_b_ff, cur_is_b_in;
   logic [XW-1:0]       col_ff, col_in;
   logic [YW-1:0]       row_ff, row_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic [3:0]          tap_ff, tap_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [HeightW-1:0]  old_ff, old_in;
   logic [HeightW-1:0]  h_ff, h_in;
   req_type             req_ff, req_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   mem_ctl_type         ctl;
   logic [ADDR_W-1:0]   wr_addr, cur_addr, prev_addr;
   logic [HeightW-1:0]  wr_data, cur_data, prev_data;
   logic [XW-1:0]       tap_x;
   logic [YW-1:0]       tap_y;
   logic [1:0]          dx, dy;
   logic                req_acc, poke_ok;
   logic [HeightW-1:0]  diff;
   logic [HeightW-1:0]  mag;

   assign req_acc = req_valid & ~req_stall;

   // poke bounds check, widened so any grid size compares correctly
   assign poke_ok = (32'(req_ff.cell_x) < 32'(GRID_W)) && (32'(req_ff.cell_y) < 32'(GRID_H));

   // neighbor tap offsets, center tap (4) reads the previous grid
   always_comb begin
      if (tap_ff >= 4'd6) begin
         dy = 2'd2;
         dx = 2'(tap_ff - 4'd6);
      end else if (tap_ff >= 4'd3) begin
         dy = 2'd1;
         dx = 2'(tap_ff - 4'd3);
      end else begin
         dy = 2'd0;
         dx = 2'(tap_ff);
      end
      tap_x = col_ff + XW'(dx) - XW'(1);
      tap_y = row_ff + YW'(dy) - YW'(1);
   end

   assign cur_addr  = {tap_y, tap_x};
   assign prev_addr = {row_ff, col_ff};

   // difference magnitude and clamp
   always_comb begin
      diff = HeightW'(sum_ff[SUM_W-1:2] - 14'(old_ff));
      if (sum_ff[SUM_W-1:2] >= 14'(old_ff)) begin
         mag = sum_ff[SUM_W-1:2] - 14'(old_ff) > 14'(limit_ff) ? limit_ff
               : diff;
      end else begin
         mag = 14'(old_ff) - sum_ff[SUM_W-1:2] > 14'(limit_ff) ? limit_ff
               : HeightW'(14'(old_ff) - sum_ff[SUM_W-1:2]);
      end
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      cur_is_b_in  = cur_is_b_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      clr_in       = clr_ff;
      tap_in       = tap_ff;
      sum_in       = sum_ff;
      old_in       = old_ff;
      h_in         = h_ff;
      req_in       = req_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_in       = rsp_ff;
      ctl          = '0;
      wr_addr      = {YW'(req_ff.cell_y), XW'(req_ff.cell_x)};
      wr_data      = req_ff.poke_value;
      req_stall    = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            ctl.clear = 1'b1;
            wr_addr   = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (&clr_ff) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_acc) begin
               req_in = req_data;
               if (req_data.cmd == CMD_ADVANCE) begin
                  state_in = ST_READ;
                  tap_in   = '0;
                  sum_in   = '0;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_READ: begin
            tap_in   = tap_ff + 4'd1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (tap_ff == 4'd5) old_in = prev_data;
            if (tap_ff != 4'd5) sum_in = sum_ff + SUM_W'(cur_data);
            if (tap_ff == 4'd9) state_in = ST_CALC;
            else begin
               tap_in = tap_ff + 4'd1;
            end
         end
         ST_CALC: begin
            h_in = (col_ff == XW'(1) || col_ff == XLast || row_ff == YW'(1) ||
                    row_ff == YLast) ? '0 : mag;
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            state_in = ST_IDLE;
            if (req_ff.cmd == CMD_POKE) begin
               ctl.wr_en = poke_ok;
            end else begin
               ctl.wr_en   = 1'b1;
               ctl.wr_prev = 1'b1;
               wr_addr     = {row_ff, col_ff};
               wr_data     = h_ff;
               rsp_valid_in = 1'b1;
               rsp_in.height = h_ff;
               rsp_in.out_x  = CoordW'(col_ff);
               rsp_in.out_y  = CoordW'(row_ff);
               rsp_in.frame_last = 1'b0;
               if (col_ff == XLast) begin
                  col_in = XW'(1);
                  if (row_ff == YLast) begin
                     row_in = YW'(1);
                     cur_is_b_in = ~cur_is_b_ff;
                     rsp_in.frame_last = 1'b1;
                  end else begin
                     row_in = row_ff + YW'(1);
                  end
               end else begin
                  col_in = col_ff + XW'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // the read issued in READ/ACC uses tap_ff; data of tap n is taken at tap n+1
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cur_is_b_ff  <= 1'b0;
         col_ff       <= XW'(1);
         row_ff       <= YW'(1);
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= HeightLimitReset;
      end else begin
         state_ff     <= state_in;
         cur_is_b_ff  <= cur_is_b_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) limit_ff <= csr_wr_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      tap_ff <= tap_in;
      sum_ff <= sum_in;
      old_ff <= old_in;
      h_ff   <= h_in;
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   wrhs_grids #(.ADDR_W(ADDR_W)) u_grids (
      .clock     (clock),
      .cur_is_b  (cur_is_b_ff),
      .ctl       (ctl),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .cur_addr  (cur_addr),
      .prev_addr (prev_addr),
      .cur_data  (cur_data),
      .prev_data (prev_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // result coordinate is never on row or column zero
   a_rsp_coord: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.out_x != '0 && rsp_data.out_y != '0))
      else $error("result coordinate on outer ring");

   // no transaction is taken during the clearing pass
   a_clear_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> req_stall)
      else $error("request accepted while clearing");

   // a stalled result is not overwritten
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result lost");

endmodule
